// File: sv/hkc_pkg.sv
`timescale 1ns / 1ps

package hkc_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_W      = 13;
    localparam int THR_W       = 12;
    localparam int RATIO_W     = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 13'd256;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd16;
    localparam logic [RATIO_W-1:0] RATIO_UNITY = 10'd16;

    // gained magnitude: |x| <= 2^(S-1), gain < 2^13, then >> 8
    localparam int MAG_W  = SAMPLE_BITS + 4;
    localparam int P_W    = $clog2(MAG_W);
    localparam int Y_W    = 31;             // Q30 mantissa
    localparam int FRAC_W = 16;
    localparam int DB_W   = 25;             // signed width of the dB constant
    localparam int L2_W   = P_W + 1 + FRAC_W;
    localparam int LP_W   = L2_W + DB_W;
    localparam int LEV_W  = LP_W - 32;

    localparam int DB_PER_LOG2_Q16 = 6313057;
    localparam int LOG2_PER_DB_Q24 = 174165;
    localparam int LOG2_DB_W       = 18;
    localparam int LEVEL_FLOOR     = -2304;

    // gain reduction path
    localparam int SLOPE_W = 16;
    localparam int SP_W    = SLOPE_W + LEV_W;
    localparam int RED_W   = SP_W + 1 - 16;
    localparam int E_W     = RED_W + LOG2_DB_W;
    localparam int N_W     = E_W - 24;
    localparam int G_W     = 31;
    localparam int ROOT_STEPS = 16;

    // slope divider: (2^20 + ratio/2) / ratio
    localparam int DVD_W     = 21;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // pipeline latencies of the sub units
    localparam int LEVEL_LAT  = 19;
    localparam int FACTOR_LAT = ROOT_STEPS + 2;
    localparam int SIDE_LAT   = LEVEL_LAT + 3 + FACTOR_LAT;
    localparam int RED_LAT    = 2 + FACTOR_LAT;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = v;
        res  = '0;
        bitv = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q30
    function automatic logic [63:0] root_q30(input int k);
        logic [63:0] r;
        r = isqrt64(64'h1 << 59);
        for (int i = 2; i <= k; i++) begin
            r = isqrt64(r << 30);
        end
        return r;
    endfunction

endpackage

// File: sv/hard_knee_compressor_gain.sv
`timescale 1ns / 1ps

// Channel   | Ports                          | Transfer
// ----------+--------------------------------+---------------------------------
// sample in | start, busy, sample_in         | edge with start high, busy low
// result    | done, sample_out, reducing     | one cycle with done high
// config    | wr_en, wr_index, wr_data       | edge with wr_en high
//
// One sample per clock while busy is low; each result follows its start through
// the pipeline: gain multiply, 16 squaring stages of the log2, dB scaling,
// reduction multiply and 16 root-multiply stages of 2^-x.
// A write of ratio 16 or more runs a bit-serial divider for the slope; busy is
// high while it runs; a lower ratio sets slope 0. Reset is asynchronous, active
// low, and clears control state; registers come up as in_gain 256, threshold 0,
// ratio 16, slope 0. The result side has no backpressure, so the pipeline never stalls.
module hard_knee_compressor_gain
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [hkc_pkg::SAMPLE_BITS-1:0]  sample_in,
    output logic                                    done,
    output logic signed [hkc_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                    reducing,
    input  logic                                    wr_en,
    input  logic [hkc_pkg::CFG_IDX_W-1:0]           wr_index,
    input  logic [hkc_pkg::CFG_DATA_W-1:0]          wr_data
);

    localparam int S     = hkc_pkg::SAMPLE_BITS;
    localparam int MW    = hkc_pkg::MAG_W;
    localparam int A_W   = MW - 16 + hkc_pkg::G_W;
    localparam int B_W   = 16 + hkc_pkg::G_W;
    localparam int RES_W = A_W + 1 - 14;

    // ---------------- configuration ----------------
    logic [hkc_pkg::GAIN_W-1:0]         in_gain_reg;
    logic signed [hkc_pkg::THR_W-1:0]   thr_reg;
    logic [hkc_pkg::RATIO_W-1:0]        ratio_reg;
    logic [hkc_pkg::SLOPE_W-1:0]        slope_reg;

    // slope divider state
    logic [hkc_pkg::DIV_CNT_W-1:0]      div_cnt_reg;
    logic [hkc_pkg::DVD_W-1:0]          dvd_reg;
    logic [hkc_pkg::RATIO_W-1:0]        rem_reg;
    logic [hkc_pkg::RATIO_W:0]          trial_c;
    logic                               ge_c;
    logic [hkc_pkg::DVD_W-1:0]          dvd_next;
    logic [hkc_pkg::RATIO_W-1:0]        rem_next;
    logic [hkc_pkg::RATIO_W-1:0]        new_ratio_c;

    assign new_ratio_c = wr_data[hkc_pkg::RATIO_W-1:0];
    assign trial_c     = {rem_reg, dvd_reg[hkc_pkg::DVD_W-1]};
    assign ge_c        = trial_c >= {1'b0, ratio_reg};

    always_comb
    begin
        rem_next = ge_c ? hkc_pkg::RATIO_W'(trial_c - {1'b0, ratio_reg})
                        : trial_c[hkc_pkg::RATIO_W-1:0];
        dvd_next = {dvd_reg[hkc_pkg::DVD_W-2:0], ge_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_gain_reg <= hkc_pkg::GAIN_RESET;
            thr_reg     <= '0;
            ratio_reg   <= hkc_pkg::RATIO_RESET;
            slope_reg   <= '0;
            div_cnt_reg <= '0;
            dvd_reg     <= '0;
            rem_reg     <= '0;
        end else begin
            if (div_cnt_reg != '0) begin
                dvd_reg     <= dvd_next;
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == hkc_pkg::DIV_CNT_W'(1)) begin
                    // slope = 1 - 1/ratio in Q16
                    slope_reg <= hkc_pkg::SLOPE_W'(17'h1_0000 - dvd_next[16:0]);
                end
            end
            if (wr_en) begin
                unique case (wr_index)
                    hkc_pkg::CFG_IN_GAIN:
                    begin
                        in_gain_reg <= wr_data[hkc_pkg::GAIN_W-1:0];
                    end
                    hkc_pkg::CFG_THRESHOLD:
                    begin
                        thr_reg <= $signed(wr_data[hkc_pkg::THR_W-1:0]);
                    end
                    hkc_pkg::CFG_RATIO:
                    begin
                        ratio_reg <= new_ratio_c;
                        rem_reg   <= '0;
                        if (new_ratio_c < hkc_pkg::RATIO_UNITY) begin
                            slope_reg   <= '0;
                            div_cnt_reg <= '0;
                        end else begin
                            dvd_reg     <= hkc_pkg::DVD_W'(21'h10_0000)
                                           + hkc_pkg::DVD_W'(new_ratio_c >> 1);
                            div_cnt_reg <= hkc_pkg::DIV_CNT_W'(hkc_pkg::DVD_W);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign busy = (div_cnt_reg != '0);

    // ---------------- stage A: rectify and input gain ----------------
    logic                 a_valid_reg;
    logic [MW-1:0]        a_mag_reg;
    logic                 a_neg_reg;
    logic [S-1:0]         amag_c;
    logic [S+hkc_pkg::GAIN_W-1:0] gprod_c;

    assign amag_c  = sample_in[S-1] ? S'(-sample_in) : S'(sample_in);
    assign gprod_c = amag_c * in_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mag_reg <= gprod_c[MW+7:8];
        a_neg_reg <= sample_in[S-1];
    end

    // side line: magnitude and sign wait for the factor
    logic [MW-1:0] side_mag_reg [1:hkc_pkg::SIDE_LAT];
    logic          side_neg_reg [1:hkc_pkg::SIDE_LAT];

    always_ff @(posedge clk)
    begin
        side_mag_reg[1] <= a_mag_reg;
        side_neg_reg[1] <= a_neg_reg;
        for (int i = 2; i <= hkc_pkg::SIDE_LAT; i++) begin
            side_mag_reg[i] <= side_mag_reg[i-1];
            side_neg_reg[i] <= side_neg_reg[i-1];
        end
    end

    // ---------------- level in dB ----------------
    logic                               lv_valid;
    logic signed [hkc_pkg::LEV_W-1:0]   lv_level;

    hkc_level u_level
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (a_valid_reg),
        .mag       (a_mag_reg),
        .valid_out (lv_valid),
        .level     (lv_level)
    );

    // ---------------- stage B: threshold and slope ----------------
    logic signed [hkc_pkg::LEV_W:0]     diff_c;
    logic                               b_valid_reg;
    logic                               b_red_reg;
    logic [hkc_pkg::SP_W-1:0]           b_prod_reg;

    assign diff_c = $signed({lv_level[hkc_pkg::LEV_W-1], lv_level})
                  - $signed((hkc_pkg::LEV_W+1)'(thr_reg));

    always_ff @(posedge clk)
    begin
        b_red_reg  <= lv_level > $signed(hkc_pkg::LEV_W'(thr_reg));
        b_prod_reg <= slope_reg * diff_c[hkc_pkg::LEV_W-1:0];
    end

    // ---------------- stage C: round to 1/16 dB ----------------
    logic                               c_valid_reg;
    logic [hkc_pkg::RED_W-1:0]          c_red_reg;
    logic [hkc_pkg::SP_W:0]             rsum_c;

    assign rsum_c = {1'b0, b_prod_reg} + (hkc_pkg::SP_W+1)'(32'h8000);

    always_ff @(posedge clk)
    begin
        c_red_reg <= rsum_c[hkc_pkg::SP_W:16];
    end

    // ---------------- stage D: dB to log2 ----------------
    logic                               d_valid_reg;
    logic [hkc_pkg::E_W-1:0]            d_e_reg;

    always_ff @(posedge clk)
    begin
        d_e_reg <= c_red_reg * hkc_pkg::LOG2_DB_W'(hkc_pkg::LOG2_PER_DB_Q24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= lv_valid;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // reducing flag waits alongside the factor
    logic red_line_reg [1:hkc_pkg::RED_LAT];

    always_ff @(posedge clk)
    begin
        red_line_reg[1] <= b_red_reg;
        for (int i = 2; i <= hkc_pkg::RED_LAT; i++) begin
            red_line_reg[i] <= red_line_reg[i-1];
        end
    end

    // ---------------- linear factor ----------------
    logic                       fc_valid;
    logic [hkc_pkg::G_W-1:0]    fc_factor;

    hkc_factor u_factor
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (d_valid_reg),
        .e         (d_e_reg),
        .valid_out (fc_valid),
        .factor    (fc_factor)
    );

    // ---------------- stage E: apply factor, split product ----------------
    logic               e_valid_reg;
    logic [A_W-1:0]     e_a_reg;
    logic [B_W-1:0]     e_b_reg;
    logic [MW-1:0]      e_mag_reg;
    logic               e_neg_reg;
    logic               e_red_reg;
    logic [MW-1:0]      mag_e_c;

    assign mag_e_c = side_mag_reg[hkc_pkg::SIDE_LAT];

    always_ff @(posedge clk)
    begin
        e_a_reg   <= mag_e_c[MW-1:16] * fc_factor;
        e_b_reg   <= mag_e_c[15:0] * fc_factor;
        e_mag_reg <= mag_e_c;
        e_neg_reg <= side_neg_reg[hkc_pkg::SIDE_LAT];
        e_red_reg <= red_line_reg[hkc_pkg::RED_LAT];
    end

    // ---------------- stage F: combine and saturate ----------------
    logic [A_W:0]       sum_c;
    logic [RES_W-1:0]   res_c;
    logic [RES_W-1:0]   sel_c;
    logic [RES_W-1:0]   lim_c;
    logic               f_valid_reg;
    logic [S-1:0]       f_out_reg;
    logic               f_red_reg;

    localparam logic [RES_W-1:0] HALF = RES_W'(1) << (S - 1);

    always_comb
    begin
        sum_c = {1'b0, e_a_reg} + (A_W+1)'(e_b_reg[B_W-1:16]);
        res_c = sum_c[A_W:14];
        sel_c = e_red_reg ? res_c : RES_W'(e_mag_reg);
        if (e_neg_reg) begin
            lim_c = (sel_c > HALF) ? HALF : sel_c;
        end else begin
            lim_c = (sel_c > HALF - 1'b1) ? HALF - 1'b1 : sel_c;
        end
    end

    always_ff @(posedge clk)
    begin
        f_out_reg <= e_neg_reg ? S'(-lim_c) : lim_c[S-1:0];
        f_red_reg <= e_red_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= fc_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    assign done       = f_valid_reg;
    assign sample_out = $signed(f_out_reg);
    assign reducing   = f_red_reg;

endmodule

// File: sv/hkc_level.sv
`timescale 1ns / 1ps

// magnitude -> level in 1/16 dBFS
module hkc_level
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  logic [hkc_pkg::MAG_W-1:0]         mag,
    output logic                              valid_out,
    output logic signed [hkc_pkg::LEV_W-1:0]  level
);

    localparam int NSQ = hkc_pkg::FRAC_W;

    logic [hkc_pkg::P_W-1:0]   p_c;
    logic [hkc_pkg::MAG_W+hkc_pkg::Y_W-1:0] norm_c;

    logic [hkc_pkg::Y_W-1:0]    y_reg    [0:NSQ];
    logic [hkc_pkg::FRAC_W-1:0] fr_reg   [0:NSQ];
    logic [hkc_pkg::P_W-1:0]    p_reg    [0:NSQ];
    logic                       zero_reg [0:NSQ+1];
    logic                       v_reg    [0:NSQ+2];

    logic signed [hkc_pkg::L2_W-1:0] l2_c;
    logic signed [hkc_pkg::LP_W-1:0] l2_ext;
    logic signed [hkc_pkg::LP_W-1:0] db_ext;
    logic signed [hkc_pkg::LP_W-1:0] prod_reg;
    logic signed [hkc_pkg::LEV_W-1:0] lev_raw;
    logic signed [hkc_pkg::LEV_W-1:0] level_reg;

    // leading one
    always_comb
    begin
        p_c = '0;
        for (int i = 0; i < hkc_pkg::MAG_W; i++) begin
            if (mag[i]) begin
                p_c = hkc_pkg::P_W'(i);
            end
        end
        norm_c = {mag, hkc_pkg::Y_W'(0)} << (hkc_pkg::P_W'(hkc_pkg::MAG_W - 1) - p_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= NSQ + 2; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else begin
            v_reg[0] <= valid_in;
            for (int i = 1; i <= NSQ + 2; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg[0]    <= norm_c[hkc_pkg::MAG_W+hkc_pkg::Y_W-1 -: hkc_pkg::Y_W];
        fr_reg[0]   <= '0;
        p_reg[0]    <= p_c;
        zero_reg[0] <= (mag == '0);
    end

    // one squaring per stage
    for (genvar s = 1; s <= NSQ; s++) begin : g_sq
        logic [2*hkc_pkg::Y_W-1:0] sq_c;
        logic [hkc_pkg::Y_W:0]     t_c;
        assign sq_c = y_reg[s-1] * y_reg[s-1];
        assign t_c  = sq_c[hkc_pkg::Y_W+30:30];
        always_ff @(posedge clk)
        begin
            y_reg[s]    <= t_c[hkc_pkg::Y_W] ? t_c[hkc_pkg::Y_W:1] : t_c[hkc_pkg::Y_W-1:0];
            fr_reg[s]   <= {fr_reg[s-1][hkc_pkg::FRAC_W-2:0], t_c[hkc_pkg::Y_W]};
            p_reg[s]    <= p_reg[s-1];
            zero_reg[s] <= zero_reg[s-1];
        end
    end

    // exponent offset and fraction form log2 in Q16
    assign l2_c   = $signed({$signed({1'b0, p_reg[NSQ]})
                    - $signed((hkc_pkg::P_W+1)'(hkc_pkg::SAMPLE_BITS - 1)), fr_reg[NSQ]});
    assign l2_ext = hkc_pkg::LP_W'(l2_c);
    assign db_ext = $signed(hkc_pkg::LP_W'(hkc_pkg::DB_PER_LOG2_Q16));

    always_ff @(posedge clk)
    begin
        prod_reg        <= l2_ext * db_ext + $signed(hkc_pkg::LP_W'(64'h8000_0000));
        zero_reg[NSQ+1] <= zero_reg[NSQ];
        level_reg       <= (zero_reg[NSQ+1]
                            || lev_raw < $signed(hkc_pkg::LEV_W'(hkc_pkg::LEVEL_FLOOR)))
                           ? $signed(hkc_pkg::LEV_W'(hkc_pkg::LEVEL_FLOOR)) : lev_raw;
    end

    assign lev_raw   = prod_reg[hkc_pkg::LP_W-1:32];
    assign level     = level_reg;
    assign valid_out = v_reg[NSQ+2];

endmodule

// File: sv/hkc_factor.sv
`timescale 1ns / 1ps

// exponent (Q24 log2) -> linear factor 2^-e in Q30
module hkc_factor
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic [hkc_pkg::E_W-1:0]      e,
    output logic                         valid_out,
    output logic [hkc_pkg::G_W-1:0]      factor
);

    localparam int NR = hkc_pkg::ROOT_STEPS;

    logic [hkc_pkg::G_W-1:0] g_reg [0:NR];
    logic [15:0]             f_reg [0:NR];
    logic [hkc_pkg::N_W-1:0] n_reg [0:NR];
    logic                    v_reg [0:NR+1];
    logic [hkc_pkg::G_W-1:0] factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= NR + 1; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else begin
            v_reg[0] <= valid_in;
            for (int i = 1; i <= NR + 1; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg[0] <= hkc_pkg::G_W'(32'h4000_0000);
        f_reg[0] <= e[23:8];
        n_reg[0] <= e[hkc_pkg::E_W-1:24];
    end

    // one root multiply per fraction bit, msb first
    for (genvar s = 1; s <= NR; s++) begin : g_root
        localparam logic [hkc_pkg::G_W-1:0] ROOT = hkc_pkg::G_W'(hkc_pkg::root_q30(s));
        logic [2*hkc_pkg::G_W-1:0] m_c;
        assign m_c = g_reg[s-1] * ROOT;
        always_ff @(posedge clk)
        begin
            g_reg[s] <= f_reg[s-1][NR-s] ? m_c[hkc_pkg::G_W+29:30] : g_reg[s-1];
            f_reg[s] <= f_reg[s-1];
            n_reg[s] <= n_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg <= (n_reg[NR] >= hkc_pkg::N_W'(31)) ? '0 : (g_reg[NR] >> n_reg[NR]);
    end

    assign factor    = factor_reg;
    assign valid_out = v_reg[NR+1];

endmodule
